// ===== src/mcfb_pkg.sv =====
// Package for the motor command frame builder: payload types, frame constants, CRC step.
`timescale 1ns / 1ps
`default_nettype none

package mcfb_pkg;

  // Drive command taken in one input transaction
  typedef struct packed {
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic        left_forward;
    logic        right_forward;
  } cmd_t;

  // One frame byte delivered per output transaction
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_t;

  // Frame byte positions
  localparam logic [3:0] POS_LEAD    = 4'd0;
  localparam logic [3:0] POS_CMD     = 4'd1;
  localparam logic [3:0] POS_LEFT_LO = 4'd2;
  localparam logic [3:0] POS_LEFT_HI = 4'd3;
  localparam logic [3:0] POS_RIGHT_LO = 4'd4;
  localparam logic [3:0] POS_RIGHT_HI = 4'd5;
  localparam logic [3:0] POS_FLAGS   = 4'd6;
  localparam logic [3:0] POS_CRC_LO  = 4'd7;
  localparam logic [3:0] POS_CRC_HI  = 4'd8;

  localparam logic [7:0]  LEAD_BYTE     = 8'hFF;
  localparam logic [7:0]  CMD_BYTE      = 8'h07;
  localparam int unsigned LEFT_FWD_BIT  = 6;
  localparam int unsigned RIGHT_FWD_BIT = 4;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  // One byte of reflected CRC-16 (eight shift/xor steps)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/motor_command_frame_builder.sv =====
// Motor command frame builder: serializes a drive command into a nine-byte CRC frame.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one drive command per
// transaction. Output channel (out_valid_o / out_ready_i / out_data_o) gives the
// frame one byte per transaction: 0xFF, 0x07, left speed lo/hi, right speed lo/hi,
// flags, CRC lo, CRC hi; last_byte marks the CRC high byte.
// The CRC (reflected 0xA001, init 0xFFFF) covers bytes 1 to 6 and is accumulated
// one byte per cycle as those bytes move into the output register, stalling with it.
// A taken command is held in cmd_q, then its first byte loads into the output register.
// Throughput: one byte per cycle while the receiver accepts, set by the
// single output byte register. A held command register lets the next command be
// taken on the cycle the last byte of the current frame is loaded.
// Reset clears the command and output valid flags and the byte counter; no frame
// is in progress afterward.
// When the receiver stalls, the output byte holds and the byte counter stops;
// in_ready_o stays low until the frame in progress reaches its last byte.
`timescale 1ns / 1ps
`default_nettype none

module motor_command_frame_builder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mcfb_pkg::cmd_t    in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mcfb_pkg::frame_t       out_data_o
);

  mcfb_pkg::cmd_t   cmd_q;
  logic             cmd_valid_q, cmd_valid_d;
  logic [3:0]       idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  mcfb_pkg::frame_t out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic             in_take;
  logic             frame_done;
  logic [7:0]       flags;
  logic [7:0]       cur_byte;
  logic [15:0]      left_spd, right_spd;

  // Output slot free or being emptied this cycle
  assign load       = cmd_valid_q && (!out_valid_q || out_ready_i);
  assign frame_done = load && (idx_q == mcfb_pkg::POS_CRC_HI);
  assign in_ready_o = !cmd_valid_q || frame_done;
  assign in_take    = in_valid_i && in_ready_o;

  // Zero speeds send zero bytes and no direction bit
  assign left_spd  = cmd_q.left_speed;
  assign right_spd = cmd_q.right_speed;
  always_comb begin
    flags = 8'h00;
    flags[mcfb_pkg::LEFT_FWD_BIT]  = (left_spd != 16'h0000) && cmd_q.left_forward;
    flags[mcfb_pkg::RIGHT_FWD_BIT] = (right_spd != 16'h0000) && cmd_q.right_forward;
  end

  // Byte select for the current frame position
  always_comb begin
    case (idx_q)
      mcfb_pkg::POS_LEAD:     cur_byte = mcfb_pkg::LEAD_BYTE;
      mcfb_pkg::POS_CMD:      cur_byte = mcfb_pkg::CMD_BYTE;
      mcfb_pkg::POS_LEFT_LO:  cur_byte = left_spd[7:0];
      mcfb_pkg::POS_LEFT_HI:  cur_byte = left_spd[15:8];
      mcfb_pkg::POS_RIGHT_LO: cur_byte = right_spd[7:0];
      mcfb_pkg::POS_RIGHT_HI: cur_byte = right_spd[15:8];
      mcfb_pkg::POS_FLAGS:    cur_byte = flags;
      mcfb_pkg::POS_CRC_LO:   cur_byte = crc_q[7:0];
      default:                cur_byte = crc_q[15:8];
    endcase
  end

  // Sequencer: counter, CRC accumulator, output register
  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_valid_d = cmd_valid_q;
    if (load) begin
      out_d.frame_byte = cur_byte;
      out_d.last_byte  = (idx_q == mcfb_pkg::POS_CRC_HI);
      out_valid_d      = 1'b1;
      if (idx_q == mcfb_pkg::POS_LEAD) begin
        crc_d = mcfb_pkg::CRC_INIT;
      end else if (idx_q inside {[mcfb_pkg::POS_CMD:mcfb_pkg::POS_FLAGS]}) begin
        crc_d = mcfb_pkg::crc_byte(crc_q, cur_byte);
      end
      if (frame_done) begin
        idx_d       = mcfb_pkg::POS_LEAD;
        cmd_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
    if (in_take) begin
      cmd_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= mcfb_pkg::POS_LEAD;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= in_data_i;
    end
    crc_q <= crc_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Counter stays within the frame
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= mcfb_pkg::POS_CRC_HI)
    else $error("frame byte counter out of range");

  // A frame in progress always has its command held
  a_mid_frame_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != mcfb_pkg::POS_LEAD) |-> cmd_valid_q)
    else $error("frame in progress without a command");

  // While the last byte waits, the counter has wrapped to the lead byte
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_byte) |-> (idx_q == mcfb_pkg::POS_LEAD))
    else $error("last byte held while counter not wrapped");

  // No new command taken mid-frame
  a_no_take_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_q && idx_q != mcfb_pkg::POS_CRC_HI) |-> !in_ready_o)
    else $error("command accepted during a frame");

  // Loading the lead byte places 0xFF in the output register
  a_lead_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && idx_q == mcfb_pkg::POS_LEAD) |=>
      (out_valid_q && out_q.frame_byte == mcfb_pkg::LEAD_BYTE && !out_q.last_byte))
    else $error("lead byte wrong");

endmodule

`default_nettype wire

// ===== tb/motor_command_frame_checker.sv =====
// Frame checker for the motor command frame builder: predicts and compares frame bytes.
`timescale 1ns / 1ps

module motor_command_frame_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  mcfb_pkg::cmd_t   in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  mcfb_pkg::frame_t out_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int FRAME_BYTES = 9;
  localparam int MAX_REPORTS = 10;

  // Frame bytes still owed by the block, oldest first
  mcfb_pkg::frame_t expected_bytes[$];

  // Reflected CRC-16 over the six covered bytes, shifted in bit by bit, LSB first
  function automatic logic [15:0] frame_crc(input logic [47:0] covered);
    logic [15:0] crc;
    logic        fb;
    crc = mcfb_pkg::CRC_INIT;
    for (int i = 0; i < 48; i++) begin
      fb  = crc[0] ^ covered[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ mcfb_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  // Queue the nine bytes that one drive command should produce
  function automatic void push_frame(input mcfb_pkg::cmd_t cmd);
    logic [7:0]       flags;
    logic [7:0]       bytes [FRAME_BYTES];
    logic [15:0]      crc;
    mcfb_pkg::frame_t fr;
    flags = 8'h00;
    // a stopped wheel never reports forward
    if (cmd.left_speed != 16'd0 && cmd.left_forward) begin
      flags[mcfb_pkg::LEFT_FWD_BIT] = 1'b1;
    end
    if (cmd.right_speed != 16'd0 && cmd.right_forward) begin
      flags[mcfb_pkg::RIGHT_FWD_BIT] = 1'b1;
    end
    bytes[mcfb_pkg::POS_LEAD]     = mcfb_pkg::LEAD_BYTE;
    bytes[mcfb_pkg::POS_CMD]      = mcfb_pkg::CMD_BYTE;
    bytes[mcfb_pkg::POS_LEFT_LO]  = cmd.left_speed[7:0];
    bytes[mcfb_pkg::POS_LEFT_HI]  = cmd.left_speed[15:8];
    bytes[mcfb_pkg::POS_RIGHT_LO] = cmd.right_speed[7:0];
    bytes[mcfb_pkg::POS_RIGHT_HI] = cmd.right_speed[15:8];
    bytes[mcfb_pkg::POS_FLAGS]    = flags;
    // lead byte is not covered by the CRC
    crc = frame_crc({bytes[mcfb_pkg::POS_FLAGS], bytes[mcfb_pkg::POS_RIGHT_HI],
                     bytes[mcfb_pkg::POS_RIGHT_LO], bytes[mcfb_pkg::POS_LEFT_HI],
                     bytes[mcfb_pkg::POS_LEFT_LO], bytes[mcfb_pkg::POS_CMD]});
    bytes[mcfb_pkg::POS_CRC_LO]   = crc[7:0];
    bytes[mcfb_pkg::POS_CRC_HI]   = crc[15:8];
    for (int k = 0; k < FRAME_BYTES; k++) begin
      fr.frame_byte = bytes[k];
      fr.last_byte  = (k == FRAME_BYTES - 1);
      expected_bytes.push_back(fr);
    end
  endfunction

  // Compare each output transaction, then queue the frame of each input transaction
  always @(posedge clk_i) begin
    mcfb_pkg::frame_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_bytes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          if (fail_count_o < MAX_REPORTS) begin
            $display("unexpected frame byte %02h last %0b at %0t",
                     out_data_i.frame_byte, out_data_i.last_byte, $realtime);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (want.frame_byte !== out_data_i.frame_byte ||
              want.last_byte !== out_data_i.last_byte) begin
            if (fail_count_o < MAX_REPORTS) begin
              $display("frame byte mismatch at %0t: expected %02h last %0b, got %02h last %0b",
                       $realtime, want.frame_byte, want.last_byte,
                       out_data_i.frame_byte, out_data_i.last_byte);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        push_frame(in_data_i);
      end
    end
    pending_o <= expected_bytes.size();
  end

endmodule

// ===== tb/motor_command_frame_builder_tb.sv =====
// Testbench top for the motor command frame builder: clock, reset, commands and verdict.
`timescale 1ns / 1ps

module motor_command_frame_builder_tb;

  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  RANDOM_CMDS   = 154;
  localparam int  HOLD_CYCLES   = 80;
  localparam int  DRAIN_CYCLES  = 20;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  mcfb_pkg::cmd_t   in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  mcfb_pkg::frame_t out_data_o;

  int     fail_count;
  int     pending;
  int     cycles;
  int     tx_idle_pct;
  int     rx_idle_pct;
  logic   hold_start;
  logic   long_hold;

  motor_command_frame_builder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  motor_command_frame_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver: random stalls, plus the long hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !long_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    long_hold = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("motor_command_frame_builder regression: fail");
      $finish;
    end
  end

  function automatic mcfb_pkg::cmd_t make_cmd(input logic [15:0] l, input logic [15:0] r,
                                              input logic lf, input logic rf);
    mcfb_pkg::cmd_t c;
    c.left_speed    = l;
    c.right_speed   = r;
    c.left_forward  = lf;
    c.right_forward = rf;
    return c;
  endfunction

  // Speeds lean on zero, full scale and single bits, the rest uniform
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one command after a random gap; returns on the accepting edge
  task automatic send_cmd(input mcfb_pkg::cmd_t c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_cmd(make_cmd(pick_speed(), pick_speed(), 1'($urandom()), 1'($urandom())));
    end
  endtask

  initial begin
    int waited;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    hold_start  = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 51;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero speeds with forward flags, full scale, single bits, patterns
    send_cmd(make_cmd(16'h0000, 16'h0000, 1'b1, 1'b1));
    send_cmd(make_cmd(16'h0000, 16'h0000, 1'b0, 1'b0));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
    send_cmd(make_cmd(16'h0000, 16'hFFFF, 1'b1, 1'b1));
    send_cmd(make_cmd(16'hFFFF, 16'h0000, 1'b1, 1'b1));
    send_cmd(make_cmd(16'h0001, 16'h8000, 1'b1, 1'b0));
    send_cmd(make_cmd(16'h0100, 16'h00FF, 1'b0, 1'b1));
    send_cmd(make_cmd(16'h8000, 16'h0001, 1'b0, 1'b1));
    send_cmd(make_cmd(16'h5555, 16'hAAAA, 1'b1, 1'b1));
    send_cmd(make_cmd(16'hAAAA, 16'h5555, 1'b0, 1'b0));
    send_cmd(make_cmd(16'h1234, 16'hFEDC, 1'b1, 1'b0));
    send_cmd(make_cmd(16'h0001, 16'h0001, 1'b1, 1'b1));
    send_cmd(make_cmd(16'h00FF, 16'hFF00, 1'b1, 1'b1));

    // Random: receiver-heavy stalls, then sender-heavy gaps, then back to back
    send_random(RANDOM_CMDS / 3);
    tx_idle_pct = 51;
    rx_idle_pct = 34;
    send_random(RANDOM_CMDS / 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start  = 1'b1;
    send_random(RANDOM_CMDS - 2 * (RANDOM_CMDS / 3));
    in_valid_i <= 1'b0;

    // Drain outstanding frame bytes, then let the block settle
    waited = 0;
    while (pending != 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("motor_command_frame_builder regression: pass");
    end else begin
      $display("motor_command_frame_builder regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mcfb_pkg.sv
src/motor_command_frame_builder.sv
tb/motor_command_frame_checker.sv
tb/motor_command_frame_builder_tb.sv
